// ===== src/rnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnc_pkg
// Shared types and constants for the resource name classifier.
// ----------------------------------------------------------------------------
package rnc_pkg;

   localparam int MAX_TEXT_LEN = 256;
   localparam int COUNT_W      = $clog2(MAX_TEXT_LEN + 2);
   localparam int FIFO_DEPTH   = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   localparam logic [11:0] GROUP_LIMIT = 12'd255;
   localparam logic [19:0] PORT_LIMIT  = 20'd65535;

   typedef enum logic [1:0] {
      KIND_FILE  = 2'd0,
      KIND_IPV4  = 2'd1,
      KIND_HOST  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      kind_type    resource_kind;
      logic [15:0] port_number;
      logic [8:0]  name_length;
   } rsp_type;

   // per-text summary handed from front to back
   typedef struct packed {
      logic        overlong;
      logic        slash;
      logic        multi_colon;
      logic        port_overflow;
      logic        quad_ok;
      logic        host_ok;
      logic        has_colon;
      logic [8:0]  text_len;
      logic [8:0]  colon_pos;
      logic [15:0] port;
   } summary_type;

endpackage

// ===== src/rnc_front.sv =====
// ----------------------------------------------------------------------------
// rnc_front
// Takes one character per cycle while accept is high, updates running parse
// state and emits a summary of the text on its last character.
// ----------------------------------------------------------------------------
module rnc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rnc_pkg::req_type     req_data,
   output logic                 sum_push,
   output rnc_pkg::summary_type sum_data
);
   import rnc_pkg::*;

   count_type   char_count_ff, char_count_in;
   logic        slash_ff, slash_in;
   logic [1:0]  colon_count_ff, colon_count_in;
   count_type   colon_pos_ff, colon_pos_in;
   logic [2:0]  group_count_ff, group_count_in;
   logic        group_nonempty_ff, group_nonempty_in;
   logic [8:0]  group_value_ff, group_value_in;
   logic        quad_valid_ff, quad_valid_in;
   logic        host_valid_ff, host_valid_in;
   logic [16:0] port_acc_ff, port_acc_in;
   logic        port_open_ff, port_open_in;
   logic        port_ovf_ff, port_ovf_in;

   logic [7:0]  c;
   logic [3:0]  digit;
   logic        is_digit, is_alpha, is_mark;
   logic [11:0] group_mul;
   logic [19:0] port_mul;

   assign c        = req_data.char_code;
   assign digit    = c[3:0];
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   assign is_mark  = (c == CHAR_DOT) || (c == CHAR_UNDER) || (c == CHAR_DASH)
                     || (c == CHAR_TILDE);

   assign group_mul = ({3'b0, group_value_ff} << 3) + ({3'b0, group_value_ff} << 1)
                      + {8'b0, digit};
   assign port_mul  = ({3'b0, port_acc_ff} << 3) + ({3'b0, port_acc_ff} << 1)
                      + {16'b0, digit};

   always_comb begin
      char_count_in     = char_count_ff;
      slash_in          = slash_ff | (c == CHAR_SLASH);
      colon_count_in    = colon_count_ff;
      colon_pos_in      = colon_pos_ff;
      group_count_in    = group_count_ff;
      group_nonempty_in = group_nonempty_ff;
      group_value_in    = group_value_ff;
      quad_valid_in     = quad_valid_ff;
      host_valid_in     = host_valid_ff;
      port_acc_in       = port_acc_ff;
      port_open_in      = port_open_ff;
      port_ovf_in       = port_ovf_ff;

      if (c == CHAR_COLON) begin
         if (colon_count_ff == 2'd0) begin
            colon_pos_in = char_count_ff;
            port_acc_in  = '0;
            port_open_in = 1'b1;
         end
         if (colon_count_ff < 2'd2) begin
            colon_count_in = colon_count_ff + 2'd1;
         end
      end else if (colon_count_ff == 2'd0) begin
         if (c == CHAR_DOT) begin
            if (group_nonempty_ff) begin
               if (group_count_ff < 3'd7) begin
                  group_count_in = group_count_ff + 3'd1;
               end
               group_nonempty_in = 1'b0;
               group_value_in    = '0;
            end else begin
               quad_valid_in = 1'b0;
            end
         end else if (is_digit) begin
            group_nonempty_in = 1'b1;
            if (group_mul > GROUP_LIMIT) begin
               quad_valid_in  = 1'b0;
               group_value_in = 9'd256;
            end else begin
               group_value_in = group_mul[8:0];
            end
         end else begin
            quad_valid_in = 1'b0;
         end
         if (char_count_ff == '0) begin
            if (!is_mark && !is_alpha) begin
               host_valid_in = 1'b0;
            end
         end else if (!is_mark && !is_alpha && !is_digit) begin
            host_valid_in = 1'b0;
         end
      end else begin
         if (port_open_ff && is_digit) begin
            if (port_mul > PORT_LIMIT) begin
               port_ovf_in = 1'b1;
               port_acc_in = 17'd65536;
            end else begin
               port_acc_in = port_mul[16:0];
            end
         end else begin
            port_open_in = 1'b0;
         end
      end

      if (char_count_ff <= COUNT_W'(MAX_TEXT_LEN)) begin
         char_count_in = char_count_ff + COUNT_W'(1);
      end
   end

   assign sum_push               = accept && req_data.last_char;
   assign sum_data.overlong      = char_count_in > COUNT_W'(MAX_TEXT_LEN);
   assign sum_data.slash         = slash_in;
   assign sum_data.multi_colon   = colon_count_in >= 2'd2;
   assign sum_data.port_overflow = port_ovf_in;
   assign sum_data.quad_ok       = quad_valid_in && (group_count_in == 3'd4)
                                   && group_nonempty_in;
   assign sum_data.host_ok       = host_valid_in;
   assign sum_data.has_colon     = colon_count_in != 2'd0;
   assign sum_data.text_len      = 9'(char_count_in);
   assign sum_data.colon_pos     = 9'(colon_pos_in);
   assign sum_data.port          = port_acc_in[15:0];

   always_ff @(posedge clock) begin
      if (reset || sum_push) begin
         char_count_ff     <= '0;
         slash_ff          <= 1'b0;
         colon_count_ff    <= '0;
         colon_pos_ff      <= '0;
         group_count_ff    <= 3'd1;
         group_nonempty_ff <= 1'b0;
         group_value_ff    <= '0;
         quad_valid_ff     <= 1'b1;
         host_valid_ff     <= 1'b1;
         port_acc_ff       <= '0;
         port_open_ff      <= 1'b0;
         port_ovf_ff       <= 1'b0;
      end else if (accept) begin
         char_count_ff     <= char_count_in;
         slash_ff          <= slash_in;
         colon_count_ff    <= colon_count_in;
         colon_pos_ff      <= colon_pos_in;
         group_count_ff    <= group_count_in;
         group_nonempty_ff <= group_nonempty_in;
         group_value_ff    <= group_value_in;
         quad_valid_ff     <= quad_valid_in;
         host_valid_ff     <= host_valid_in;
         port_acc_ff       <= port_acc_in;
         port_open_ff      <= port_open_in;
         port_ovf_ff       <= port_ovf_in;
      end
   end

`ifndef SYNTHESIS
   a_restart: assert property (@(posedge clock) disable iff (reset)
      sum_push |=> (char_count_ff == '0) && (colon_count_ff == '0) && quad_valid_ff)
      else $error("front state not cleared after last character");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= COUNT_W'(MAX_TEXT_LEN + 1))
      else $error("character count past saturation");
`endif

endmodule

// ===== src/rnc_fifo.sv =====
// ----------------------------------------------------------------------------
// rnc_fifo
// Short summary queue between front and back.
// ----------------------------------------------------------------------------
module rnc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  rnc_pkg::summary_type wr_data,
   input  logic                 rd_en,
   output rnc_pkg::summary_type rd_data,
   output logic                 fifo_full,
   output logic                 fifo_empty
);
   import rnc_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   summary_type             entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_wr, do_rd;

   assign fifo_full  = count_ff == CNT_W'(FIFO_DEPTH);
   assign fifo_empty = count_ff == '0;
   assign do_wr      = wr_en && !fifo_full;
   assign do_rd      = rd_en && !fifo_empty;
   assign rd_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("summary queue count out of range");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !fifo_full)
      else $error("summary written into full queue");
`endif

endmodule

// ===== src/rnc_back.sv =====
// ----------------------------------------------------------------------------
// rnc_back
// Resolves a text summary into kind, port and name length and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module rnc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sum_valid,
   input  rnc_pkg::summary_type sum_data,
   output logic                 sum_pop,
   input  logic                 pop,
   output logic                 empty,
   output rnc_pkg::rsp_type     rsp_data
);
   import rnc_pkg::*;

   logic    out_valid_ff;
   rsp_type out_ff, out_in;

   always_comb begin
      out_in.resource_kind = KIND_ERROR;
      out_in.port_number   = '0;
      out_in.name_length   = '0;
      if (sum_data.overlong) begin
         out_in.resource_kind = KIND_ERROR;
      end else if (sum_data.slash) begin
         out_in.resource_kind = KIND_FILE;
         out_in.name_length   = sum_data.text_len;
      end else if (sum_data.multi_colon || sum_data.port_overflow) begin
         out_in.resource_kind = KIND_ERROR;
      end else if (sum_data.quad_ok || sum_data.host_ok) begin
         out_in.resource_kind = sum_data.quad_ok ? KIND_IPV4 : KIND_HOST;
         out_in.name_length   = sum_data.has_colon ? sum_data.colon_pos : sum_data.text_len;
         out_in.port_number   = sum_data.has_colon ? sum_data.port : 16'd0;
      end
   end

   assign sum_pop  = sum_valid && (!out_valid_ff || pop);
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         out_ff <= out_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (sum_pop) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.resource_kind == KIND_ERROR))
      |-> (rsp_data.port_number == '0) && (rsp_data.name_length == '0))
      else $error("error result carries port or length");
   a_file_no_port: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.resource_kind == KIND_FILE)) |-> (rsp_data.port_number == '0))
      else $error("file path result carries a port");
`endif

endmodule

// ===== src/resource_name_classifier.sv =====
// ----------------------------------------------------------------------------
// resource_name_classifier
// Classifies a resource text as file path, IPv4 host, host name or error.
// ----------------------------------------------------------------------------
// One character is accepted per clock while full is low; the front registers
// its running parse state on each accepted character, so texts stream back to
// back with no gap between them. On the character marked last, a summary
// enters a two-entry queue and the back stage resolves it into the output
// register once that register is empty or being popped. full rises only while
// the queue holds two pending texts behind a result not yet popped.
module resource_name_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rnc_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output rnc_pkg::rsp_type rsp_data
);
   import rnc_pkg::*;

   logic        accept;
   logic        sum_push, sum_pop, fifo_empty;
   summary_type sum_in, sum_out;

   assign accept = push && !full;

   rnc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .sum_push (sum_push),
      .sum_data (sum_in)
   );

   rnc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (sum_push),
      .wr_data    (sum_in),
      .rd_en      (sum_pop),
      .rd_data    (sum_out),
      .fifo_full  (full),
      .fifo_empty (fifo_empty)
   );

   rnc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (!fifo_empty),
      .sum_data  (sum_out),
      .sum_pop   (sum_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/resource_name_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// resource_name_classifier_tb
// Self-checking bench for the resource name classifier.
// ----------------------------------------------------------------------------
// Texts go in one character per item: first a set of directed texts, then
// random IPv4, host name, file path and garbage texts. A character-level parse
// model turns every accepted character into an expected classification.
// Results are checked field by field, in order. The sender runs in bursts
// with random gaps, and the receiver stalls in random runs.
module resource_name_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rnc_pkg::*;

   localparam int RANDOM_CHARS = 890;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   req_type    char_stream[$];
   rsp_type    expected_classes[$];
   byte unsigned text_buf[$];

   int mismatches  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int gap_left    = 0;
   int stall_left  = 0;

   // running parse state
   logic [8:0]  n_chars;
   logic        saw_slash;
   logic [1:0]  colons;
   logic [8:0]  colon_at;
   logic [2:0]  groups;
   logic        group_has_digit;
   logic [8:0]  group_val;
   logic        ipv4_ok;
   logic        name_ok;
   logic [16:0] port_val;
   logic        port_open;
   logic        port_too_big;

   resource_name_classifier DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic logic digit_ch(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic alpha_ch(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic mark_ch(input logic [7:0] c);
      return c == CHAR_DOT || c == CHAR_UNDER || c == CHAR_DASH || c == CHAR_TILDE;
   endfunction

   function automatic void clear_parse();
      n_chars         = '0;
      saw_slash       = 1'b0;
      colons          = '0;
      colon_at        = '0;
      groups          = 3'd1;
      group_has_digit = 1'b0;
      group_val       = '0;
      ipv4_ok         = 1'b1;
      name_ok         = 1'b1;
      port_val        = '0;
      port_open       = 1'b0;
      port_too_big    = 1'b0;
   endfunction

   function automatic void classify_char(input req_type r);
      logic [7:0] c;
      int         v;
      rsp_type    res;
      c = r.char_code;
      if (c == CHAR_SLASH) saw_slash = 1'b1;
      if (c == CHAR_COLON) begin
         if (colons == 2'd0) begin
            colon_at  = n_chars;
            port_val  = '0;
            port_open = 1'b1;
         end
         if (colons < 2'd2) colons = colons + 2'd1;
      end else if (colons == 2'd0) begin
         if (c == CHAR_DOT) begin
            if (group_has_digit) begin
               if (groups < 3'd7) groups = groups + 3'd1;
               group_has_digit = 1'b0;
               group_val       = '0;
            end else begin
               ipv4_ok = 1'b0;
            end
         end else if (digit_ch(c)) begin
            v = int'(group_val) * 10 + int'(c) - int'(CHAR_ZERO);
            group_has_digit = 1'b1;
            if (v > 255) begin
               ipv4_ok = 1'b0;
               v = 256;
            end
            group_val = v[8:0];
         end else begin
            ipv4_ok = 1'b0;
         end
         if (!mark_ch(c) && !alpha_ch(c) && (n_chars == 0 || !digit_ch(c)))
            name_ok = 1'b0;
      end else begin
         if (port_open && digit_ch(c)) begin
            v = int'(port_val) * 10 + int'(c) - int'(CHAR_ZERO);
            if (v > 65535) begin
               port_too_big = 1'b1;
               v = 65536;
            end
            port_val = v[16:0];
         end else begin
            port_open = 1'b0;
         end
      end
      if (n_chars <= MAX_TEXT_LEN) n_chars = n_chars + 9'd1;

      if (r.last_char) begin
         res = '0;
         if (n_chars > MAX_TEXT_LEN) begin
            res.resource_kind = KIND_ERROR;
         end else if (saw_slash) begin
            res.resource_kind = KIND_FILE;
            res.name_length   = n_chars;
         end else if (colons >= 2'd2 || port_too_big) begin
            res.resource_kind = KIND_ERROR;
         end else begin
            if (ipv4_ok && groups == 3'd4 && group_has_digit)
               res.resource_kind = KIND_IPV4;
            else if (name_ok)
               res.resource_kind = KIND_HOST;
            else
               res.resource_kind = KIND_ERROR;
            if (res.resource_kind != KIND_ERROR) begin
               res.name_length = (colons != 2'd0) ? colon_at : n_chars;
               res.port_number = (colons != 2'd0) ? port_val[15:0] : 16'd0;
            end
         end
         expected_classes.push_back(res);
         clear_parse();
      end
   endfunction

   // ---- text building ----
   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic add_num(input int n);
      add_str($sformatf("%0d", n));
   endtask

   task automatic commit_text();
      for (int i = 0; i < text_buf.size(); i++)
         char_stream.push_back(req_type'{char_code: text_buf[i],
                                         last_char: (i == text_buf.size() - 1)});
      text_buf.delete();
   endtask

   task automatic put_text(input string s);
      add_str(s);
      commit_text();
   endtask

   function automatic byte unsigned name_char();
      byte unsigned marks[4];
      marks = '{CHAR_DOT, CHAR_UNDER, CHAR_DASH, CHAR_TILDE};
      case ($urandom_range(0, 4))
         0: return byte'($urandom_range(8'h41, 8'h5A));
         1: return byte'($urandom_range(8'h61, 8'h7A));
         2: return byte'($urandom_range(8'h30, 8'h39));
         3: return marks[$urandom_range(0, 3)];
         default: return byte'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   task automatic add_port_tail();
      int sel;
      sel = $urandom_range(0, 9);
      text_buf.push_back(CHAR_COLON);
      case (sel)
         0: ;
         1: add_num($urandom_range(65530, 65545));
         2: add_num($urandom_range(65536, 9999999));
         3: begin
            add_num($urandom_range(0, 9999));
            text_buf.push_back(name_char());
            add_num($urandom_range(0, 99));
         end
         4: begin
            add_num($urandom_range(0, 999));
            text_buf.push_back(CHAR_COLON);
            add_num($urandom_range(0, 99));
         end
         5: begin
            add_str("00");
            add_num($urandom_range(0, 999));
         end
         default: add_num($urandom_range(0, 65535));
      endcase
   endtask

   task automatic make_random_text();
      int sel;
      int n;
      int pos;
      sel = $urandom_range(0, 149);
      if (sel == 0) begin
         n = $urandom_range(250, 262);
         repeat (n) text_buf.push_back(name_char());
      end else if (sel < 55) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 4;
         for (int g = 0; g < n; g++) begin
            if (g > 0) text_buf.push_back(CHAR_DOT);
            if ($urandom_range(0, 24) == 0) continue;
            if ($urandom_range(0, 9) == 0) text_buf.push_back(CHAR_ZERO);
            if ($urandom_range(0, 7) == 0) add_num($urandom_range(256, 9999));
            else add_num($urandom_range(0, 255));
         end
         if ($urandom_range(0, 19) == 0) text_buf.push_back(CHAR_DOT);
         if ($urandom_range(0, 2) != 0) add_port_tail();
      end else if (sel < 95) begin
         n = $urandom_range(0, 12);
         if (n > 0)
            text_buf.push_back(($urandom_range(0, 5) == 0) ?
                               byte'($urandom_range(8'h30, 8'h39)) : name_char());
         for (int i = 1; i < n; i++) text_buf.push_back(name_char());
         if ($urandom_range(0, 2) != 0) add_port_tail();
      end else if (sel < 115) begin
         n = $urandom_range(1, 14);
         repeat (n) text_buf.push_back(byte'($urandom_range(8'h21, 8'h7E)));
         pos = $urandom_range(0, n);
         text_buf.insert(pos, CHAR_SLASH);
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) text_buf.push_back(CHAR_COLON);
            else text_buf.push_back(byte'($urandom_range(0, 255)));
         end
      end
      if (text_buf.size() == 0) text_buf.push_back(name_char());
   endtask

   // ---- driver: bursts with gaps, prediction on acceptance ----
   always @(posedge clock) begin
      logic nxt_push;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            classify_char(req_data);
            void'(char_stream.pop_front());
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = (cycle_count[10:9] == 2'd0 || $urandom_range(0, 2) == 0) ?
                            0 : $urandom_range(1, 6);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            nxt_push = 1'b0;
         end else begin
            nxt_push = (char_stream.size() > 0);
         end
         push <= nxt_push;
         if (nxt_push) req_data <= char_stream[0];
      end
   end

   // ---- receiver stalls and result check ----
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_classes.size() == 0) begin
               $error("result with no expectation: kind %0d port %0d length %0d",
                      rsp_data.resource_kind, rsp_data.port_number,
                      rsp_data.name_length);
               mismatches++;
            end else begin
               want = expected_classes.pop_front();
               if (rsp_data.resource_kind !== want.resource_kind) begin
                  $error("resource_kind: expected %0d, actual %0d",
                         want.resource_kind, rsp_data.resource_kind);
                  mismatches++;
               end
               if (rsp_data.port_number !== want.port_number) begin
                  $error("port_number: expected %0d, actual %0d",
                         want.port_number, rsp_data.port_number);
                  mismatches++;
               end
               if (rsp_data.name_length !== want.name_length) begin
                  $error("name_length: expected %0d, actual %0d",
                         want.name_length, rsp_data.name_length);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (cycle_count[8:7] != 2'd0 && $urandom_range(0, 3) == 0)
               stall_left = $urandom_range(1, 5);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int random_chars;
      random_chars = 0;
      clear_parse();

      put_text("/");
      put_text("a/b:99");
      put_text("192.168.0.1:8080");
      put_text("255.255.255.255:65535");
      put_text("0.0.0.0");
      put_text("1.2.3.256");
      put_text("1.2.3.4.");
      put_text("1.2.3");
      put_text("1.2.3.4.5");
      put_text("1..2.3");
      put_text("host:65536");
      put_text("h:99999999");
      put_text("a:b:c");
      put_text("a:/b:c");
      put_text("srv:80x9");
      put_text("x:");
      put_text(":80");
      put_text("~a_b-c.d");
      put_text("9abc");
      put_text(".");
      add_str("a");
      text_buf.push_back(8'h00);
      commit_text();
      text_buf.push_back(8'hFF);
      text_buf.push_back(8'h80);
      commit_text();
      repeat (MAX_TEXT_LEN) text_buf.push_back(8'h61);
      commit_text();
      repeat (MAX_TEXT_LEN + 1) text_buf.push_back(8'h61);
      commit_text();

      while (random_chars < RANDOM_CHARS) begin
         make_random_text();
         random_chars += text_buf.size();
         commit_text();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (char_stream.size() != 0 || expected_classes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
